@@ rtl/core/tiny_accumulator_cpu_defines.svh @@
// Assertion macros shared by the checker of the accumulator machine.
// Depends on nothing; included by the checker file.
`ifndef TINY_ACCUMULATOR_CPU_DEFINES_SVH
`define TINY_ACCUMULATOR_CPU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TACPU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tacpu check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TACPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tacpu check failed");

`endif

@@ rtl/core/tacpu_pkg.sv @@
// Shared types and constants of the accumulator machine.
// Depends on nothing; used by the top level and the sequencer.
package tacpu_pkg;

    localparam int MEMORY_WORDS = 32;
    localparam int ADDR_W       = $clog2(MEMORY_WORDS);
    localparam int DATA_W       = 8;
    localparam int OPC_W        = DATA_W - ADDR_W;
    localparam int STEP_W       = 16;

    localparam logic [ADDR_W-1:0] LAST_ADDR        = ADDR_W'(MEMORY_WORDS - 1);
    localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = {STEP_W{1'b1}};

    typedef enum logic [OPC_W-1:0] {
        OP_STA = 3'd0,
        OP_LDA = 3'd1,
        OP_BEQ = 3'd2,
        OP_NOP = 3'd3,
        OP_DEC = 3'd4,
        OP_INC = 3'd5,
        OP_JMP = 3'd6,
        OP_HLT = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_EXEC,
        S_LDACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

@@ rtl/core/tiny_accumulator_cpu.sv @@
// Accumulator machine: a byte is taken each cycle while busy is low and start is high; the 32nd byte starts a run.
// A run steps each instruction through FETCH and EXEC, LDA also through LDACC, as the RAM read is registered.
// The result strobe comes in the cycle after the halting or timed-out step; busy drops after it.
// Synchronous active-low reset clears counters, accumulator and state; the step limit resets to 65535.
module tiny_accumulator_cpu (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [tacpu_pkg::DATA_W-1:0]       i_program_byte,
    output logic                               o_done,
    output logic [tacpu_pkg::DATA_W-1:0]       o_accumulator_value,
    output logic                               o_timed_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tacpu_pkg::STEP_W-1:0]       i_cfg_data
);

    logic [tacpu_pkg::STEP_W-1:0] r_step_limit;
    tacpu_pkg::t_mem_req          w_mem;
    logic [tacpu_pkg::DATA_W-1:0] w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= tacpu_pkg::STEP_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_step_limit <= i_cfg_data;
        end
    end

    tacpu_ram #(
        .WIDTH (tacpu_pkg::DATA_W),
        .DEPTH (tacpu_pkg::MEMORY_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    tacpu_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_program_byte      (i_program_byte),
        .i_step_limit        (r_step_limit),
        .i_rdata             (w_rdata),
        .o_mem               (w_mem),
        .o_busy              (o_busy),
        .o_done              (o_done),
        .o_accumulator_value (o_accumulator_value),
        .o_timed_out         (o_timed_out)
    );

endmodule

@@ rtl/core/tacpu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module tacpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tacpu_seq.sv @@
// Sequencer of the accumulator machine: load counter, fetch and execute control.
// Depends on tacpu_pkg; drives the program memory through a request struct.
module tacpu_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [tacpu_pkg::DATA_W-1:0]        i_program_byte,
    input  logic [tacpu_pkg::STEP_W-1:0]        i_step_limit,
    input  logic [tacpu_pkg::DATA_W-1:0]        i_rdata,
    output tacpu_pkg::t_mem_req                 o_mem,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [tacpu_pkg::DATA_W-1:0]        o_accumulator_value,
    output logic                                o_timed_out
);

    tacpu_pkg::t_state                  r_state, n_state;
    logic [tacpu_pkg::ADDR_W-1:0]       r_load_count, n_load_count;
    logic [tacpu_pkg::ADDR_W-1:0]       r_pc, n_pc;
    logic [tacpu_pkg::DATA_W-1:0]       r_acc, n_acc;
    logic [tacpu_pkg::STEP_W-1:0]       r_steps, n_steps;
    logic                               r_timed_out, n_timed_out;

    tacpu_pkg::t_opcode                 w_opc;
    logic [tacpu_pkg::ADDR_W-1:0]       w_arg;
    logic                               w_limit_hit;

    assign w_opc       = tacpu_pkg::t_opcode'(i_rdata[tacpu_pkg::DATA_W-1:tacpu_pkg::ADDR_W]);
    assign w_arg       = i_rdata[tacpu_pkg::ADDR_W-1:0];
    assign w_limit_hit = (r_steps == i_step_limit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tacpu_pkg::S_LOAD: begin
                if (i_start && (r_load_count == tacpu_pkg::LAST_ADDR)) begin
                    n_state = tacpu_pkg::S_FETCH;
                end
            end
            tacpu_pkg::S_FETCH: begin
                n_state = w_limit_hit ? tacpu_pkg::S_DONE : tacpu_pkg::S_EXEC;
            end
            tacpu_pkg::S_EXEC: begin
                unique case (w_opc)
                    tacpu_pkg::OP_LDA: n_state = tacpu_pkg::S_LDACC;
                    tacpu_pkg::OP_HLT: n_state = tacpu_pkg::S_DONE;
                    default:           n_state = tacpu_pkg::S_FETCH;
                endcase
            end
            tacpu_pkg::S_LDACC: n_state = tacpu_pkg::S_FETCH;
            tacpu_pkg::S_DONE:  n_state = tacpu_pkg::S_LOAD;
            default:            n_state = tacpu_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        n_load_count = r_load_count;
        n_pc         = r_pc;
        n_acc        = r_acc;
        n_steps      = r_steps;
        n_timed_out  = r_timed_out;
        o_mem        = '0;
        o_mem.raddr  = r_pc;
        o_busy       = 1'b1;
        o_done       = 1'b0;
        unique case (r_state)
            tacpu_pkg::S_LOAD: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_mem.we     = 1'b1;
                    o_mem.waddr  = r_load_count;
                    o_mem.wdata  = i_program_byte;
                    n_load_count = r_load_count + 1'b1;
                    n_pc         = '0;
                    n_acc        = '0;
                    n_steps      = '0;
                end
            end
            tacpu_pkg::S_FETCH: begin
                if (w_limit_hit) begin
                    n_timed_out = 1'b1;
                end else begin
                    n_steps = r_steps + 1'b1;
                    n_pc    = r_pc + 1'b1;
                end
            end
            tacpu_pkg::S_EXEC: begin
                o_mem.raddr = w_arg;
                unique case (w_opc)
                    tacpu_pkg::OP_STA: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = w_arg;
                        o_mem.wdata = r_acc;
                    end
                    tacpu_pkg::OP_BEQ: begin
                        if (r_acc == '0) begin
                            n_pc = w_arg;
                        end
                    end
                    tacpu_pkg::OP_DEC: n_acc = r_acc - 1'b1;
                    tacpu_pkg::OP_INC: n_acc = r_acc + 1'b1;
                    tacpu_pkg::OP_JMP: n_pc = w_arg;
                    tacpu_pkg::OP_HLT: n_timed_out = 1'b0;
                    default: ;
                endcase
            end
            tacpu_pkg::S_LDACC: n_acc = i_rdata;
            tacpu_pkg::S_DONE:  o_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tacpu_pkg::S_LOAD;
            r_load_count <= '0;
            r_pc         <= '0;
            r_acc        <= '0;
            r_steps      <= '0;
            r_timed_out  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_count <= n_load_count;
            r_pc         <= n_pc;
            r_acc        <= n_acc;
            r_steps      <= n_steps;
            r_timed_out  <= n_timed_out;
        end
    end

    assign o_accumulator_value = r_acc;
    assign o_timed_out         = r_timed_out;

endmodule

@@ rtl/core/tacpu_checker.sv @@
// Port-level checker of the accumulator machine, bound to the top level.
// Depends on the assertion macros in tiny_accumulator_cpu_defines.svh.
`include "tiny_accumulator_cpu_defines.svh"

module tacpu_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_busy,
    input logic                               o_done
);

    `TACPU_ASSERT_SAME(a_done_while_busy, i_clk, i_rst_n, o_done, o_busy)
    `TACPU_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `TACPU_ASSERT_NEXT(a_idle_after_done, i_clk, i_rst_n, o_done, !o_busy)
    `TACPU_ASSERT_SAME(a_busy_ends_by_done, i_clk, i_rst_n, $fell(o_busy), $past(o_done))

endmodule

bind tiny_accumulator_cpu tacpu_checker u_tacpu_checker (.*);
